// File: src/efd_pkg.sv
`default_nettype none

package efd_pkg;

   localparam int BUFFER_BYTES = 1024;
   localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);
   localparam int MAGIC_BYTES  = 4;
   localparam int CMD_END      = 8;
   localparam int BODY_START   = 16;
   localparam int TAIL_BYTES   = 4;
   localparam int MIN_PACKET   = 4 + 4 + 8 + 4;

   localparam logic [31:0] MAGIC_RESET = 32'h7313_3C2C;
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [15:0] STRAY_MAX   = 16'hFFFF;

   localparam logic [7:0] ESC_BYTE    = 8'hFF;
   localparam logic [7:0] ESC_LITERAL = 8'h11;
   localparam logic [7:0] ESC_START   = 8'h22;
   localparam logic [7:0] ESC_END     = 8'h33;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 144;
   localparam int RSP_USER_W  = 2;

   typedef enum logic {
      REG_EXPECTED_MAGIC = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_RESET  = 2'd2,
      KIND_UNUSED = 2'd3
   } in_kind_type;

   typedef enum logic [1:0] {
      RES_PAYLOAD = 2'd0,
      RES_ACCEPT  = 2'd1,
      RES_REJECT  = 2'd2,
      RES_REPORT  = 2'd3
   } res_kind_type;

   typedef enum logic [2:0] {
      REASON_NONE     = 3'd0,
      REASON_SHORT    = 3'd1,
      REASON_MAGIC    = 3'd2,
      REASON_CRC      = 3'd3,
      REASON_OVERFLOW = 3'd4,
      REASON_SYMBOL   = 3'd5
   } reason_type;

   typedef enum logic [1:0] {
      SYM_DATA  = 2'd0,
      SYM_START = 2'd1,
      SYM_END   = 2'd2,
      SYM_ERROR = 2'd3
   } sym_type;

   typedef struct packed {
      in_kind_type kind;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      res_kind_type result_kind;
      logic [7:0]   payload_byte;
      logic [9:0]   payload_offset;
      logic [31:0]  cmd_word;
      logic [63:0]  stamp_word;
      logic [9:0]   payload_length;
      reason_type   reject_reason;
      logic [15:0]  error_count;
   } rsp_item_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/escaped_frame_decoder_crc32_unit.sv
// Channel | Direction | Handshake                  | Contents
// req     | in        | req_tvalid / req_tready    | tuser kind, tdata raw byte
// rsp     | out       | rsp_tvalid / rsp_tready    | tuser result kind, tdata fields
// csr     | in        | csr_psel/penable, pready=1 | expected_magic at byte address 0
//
// One word per cycle while rsp is not stalled: a word is held in the input register, then the
// escape, framing and byte-wide CRC-32 update run on it into the result register.
// A result reaches rsp from its word through the input register and then the result register.
// Reset is synchronous; it restores expected_magic and clears the decoder state.
// A stalled result holds the core; the input register takes one more word meanwhile.
`default_nettype none

module escaped_frame_decoder_crc32_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [efd_pkg::REQ_DATA_W-1:0]     req_tdata,  // data_byte
   input  wire logic [efd_pkg::REQ_USER_W-1:0]     req_tuser,  // kind
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // payload_byte, payload_offset, cmd_word, stamp_word, payload_length,
   // reject_reason, error_count, zero pad
   output logic [efd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [efd_pkg::RSP_USER_W-1:0]          rsp_tuser,  // result_kind
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [efd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [efd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [efd_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);
   import efd_pkg::*;

   logic [31:0]   magic_ff, magic_in;
   reg_index_type csr_index;
   logic          csr_write;

   req_item_type  req_item;
   req_item_type  item;
   logic          item_valid;
   logic          advance;
   logic          res_valid;
   rsp_item_type  res;
   rsp_item_type  rsp_item;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_index == REG_EXPECTED_MAGIC);

   always_comb begin
      magic_in = magic_ff;
      if (csr_write) begin
         magic_in = csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_EXPECTED_MAGIC: csr_prdata = magic_ff;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else begin
         magic_ff <= magic_in;
      end
   end

   assign req_item.kind      = in_kind_type'(req_tuser);
   assign req_item.data_byte = req_tdata;
   assign advance            = item_valid && (!rsp_tvalid || rsp_tready);

   efd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   efd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (item),
      .expected_magic (magic_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   efd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .load_item  (res),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_item   (rsp_item)
   );

   assign rsp_tuser = rsp_item.result_kind;
   assign rsp_tdata = {1'b0, rsp_item.error_count, rsp_item.reject_reason,
                       rsp_item.payload_length, rsp_item.stamp_word,
                       rsp_item.cmd_word, rsp_item.payload_offset,
                       rsp_item.payload_byte};

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   a_no_input_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!item_valid || advance))
      else $error("input register overwritten before use");

   a_report_follows: assert property (@(posedge clock) disable iff (reset)
      (advance && item.kind == KIND_REPORT) |=> (rsp_tvalid && rsp_tuser == RES_REPORT))
      else $error("report word did not produce a report result");

   a_quiet_kinds: assert property (@(posedge clock) disable iff (reset)
      (advance && (item.kind == KIND_RESET || item.kind == KIND_UNUSED)) |-> !res_valid)
      else $error("decoder reset or unused kind produced a result");

endmodule

`default_nettype wire

// File: src/efd_in_reg.sv
`default_nettype none

module efd_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire efd_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output efd_pkg::req_item_type      item
);
   import efd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: src/efd_core.sv
`default_nettype none

module efd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire efd_pkg::req_item_type item,
   input  wire logic [31:0]           expected_magic,
   output logic                       res_valid,
   output efd_pkg::rsp_item_type      res
);
   import efd_pkg::*;

   logic               esc_ff, esc_in;
   logic               in_pkt_ff, in_pkt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        stray_ff, stray_in;
   logic [31:0]        tail_ff, tail_in;
   logic [31:0]        crc_ff, crc_in;
   logic [31:0]        magic_ff, magic_in;
   logic [31:0]        cmd_ff, cmd_in;
   logic [63:0]        ts_ff, ts_in;

   always_comb begin
      logic       take;
      sym_type    sym;
      logic [7:0] b;
      esc_in    = esc_ff;
      in_pkt_in = in_pkt_ff;
      count_in  = count_ff;
      stray_in  = stray_ff;
      tail_in   = tail_ff;
      crc_in    = crc_ff;
      magic_in  = magic_ff;
      cmd_in    = cmd_ff;
      ts_in     = ts_ff;
      res       = '0;
      res_valid = 1'b0;
      take      = 1'b0;
      sym       = SYM_DATA;
      b         = item.data_byte;

      unique case (item.kind)
         KIND_REPORT: begin
            res.result_kind = RES_REPORT;
            res.error_count = stray_ff;
            res_valid       = 1'b1;
            stray_in        = '0;
         end
         KIND_RESET: begin
            esc_in    = 1'b0;
            in_pkt_in = 1'b0;
            count_in  = '0;
         end
         KIND_BYTE: begin
            if (esc_ff) begin
               esc_in = 1'b0;
               take   = 1'b1;
               unique case (item.data_byte)
                  ESC_LITERAL: begin
                     sym = SYM_DATA;
                     b   = ESC_BYTE;
                  end
                  ESC_START: sym = SYM_START;
                  ESC_END:   sym = SYM_END;
                  default:   sym = SYM_ERROR;
               endcase
            end else if (item.data_byte == ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               take = 1'b1;
            end
         end
         default: ;
      endcase

      if (take) begin
         if (!in_pkt_ff) begin
            if (sym == SYM_START) begin
               in_pkt_in = 1'b1;
               count_in  = '0;
               tail_in   = '0;
               crc_in    = CRC_INIT;
               magic_in  = '0;
               cmd_in    = '0;
               ts_in     = '0;
            end else if (stray_ff != STRAY_MAX) begin
               stray_in = stray_ff + 16'd1;
            end
         end else begin
            case (sym)
               SYM_DATA: begin
                  if (count_ff >= COUNT_W'(BUFFER_BYTES)) begin
                     in_pkt_in         = 1'b0;
                     res.result_kind   = RES_REJECT;
                     res.reject_reason = REASON_OVERFLOW;
                     res_valid         = 1'b1;
                  end else begin
                     if (count_ff < COUNT_W'(MAGIC_BYTES)) begin
                        magic_in = {magic_ff[23:0], b};
                     end else if (count_ff < COUNT_W'(CMD_END)) begin
                        cmd_in = {cmd_ff[23:0], b};
                     end else if (count_ff < COUNT_W'(BODY_START)) begin
                        ts_in = {ts_ff[55:0], b};
                     end
                     if (count_ff >= COUNT_W'(TAIL_BYTES)) begin
                        crc_in = crc_byte(crc_ff, tail_ff[31:24]);
                        if (count_ff >= COUNT_W'(TAIL_BYTES + BODY_START)) begin
                           res.result_kind    = RES_PAYLOAD;
                           res.payload_byte   = tail_ff[31:24];
                           res.payload_offset =
                              10'(count_ff - COUNT_W'(TAIL_BYTES + BODY_START));
                           res_valid          = 1'b1;
                        end
                     end
                     tail_in  = {tail_ff[23:0], b};
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               SYM_END: begin
                  in_pkt_in       = 1'b0;
                  res_valid       = 1'b1;
                  res.result_kind = RES_REJECT;
                  if (count_ff < COUNT_W'(MIN_PACKET)) begin
                     res.reject_reason = REASON_SHORT;
                  end else if (magic_ff != expected_magic) begin
                     res.reject_reason = REASON_MAGIC;
                  end else if (~crc_ff != tail_ff) begin
                     res.reject_reason = REASON_CRC;
                  end else begin
                     res.result_kind    = RES_ACCEPT;
                     res.cmd_word       = cmd_ff;
                     res.stamp_word     = ts_ff;
                     res.payload_length = 10'(count_ff - COUNT_W'(MIN_PACKET));
                  end
               end
               default: begin
                  in_pkt_in         = 1'b0;
                  res.result_kind   = RES_REJECT;
                  res.reject_reason = REASON_SYMBOL;
                  res_valid         = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff    <= 1'b0;
         in_pkt_ff <= 1'b0;
         count_ff  <= '0;
         stray_ff  <= '0;
      end else if (advance) begin
         esc_ff    <= esc_in;
         in_pkt_ff <= in_pkt_in;
         count_ff  <= count_in;
         stray_ff  <= stray_in;
      end
      if (advance) begin
         tail_ff  <= tail_in;
         crc_ff   <= crc_in;
         magic_ff <= magic_in;
         cmd_ff   <= cmd_in;
         ts_ff    <= ts_in;
      end
   end

endmodule

`default_nettype wire

// File: src/efd_out_reg.sv
`default_nettype none

module efd_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire efd_pkg::rsp_item_type load_item,
   input  wire logic                  rsp_tready,
   output logic                       rsp_valid,
   output efd_pkg::rsp_item_type      rsp_item
);
   import efd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire
